// File: design/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
// No dependencies; every other design file uses this package.
package lps_pkg;

	localparam int COORD_BITS = 11;
	localparam int DEC_BITS   = COORD_BITS + 3;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	// One classified command, passed from the front end to the back end.
	typedef struct packed {
		logic   is_load;
		coord_t xs;
		coord_t ys;
		coord_t major;
		logic   x_back;
		logic   y_back;
		logic   steep;
		dec_t   dec_init;
		dec_t   inc_neg;
		dec_t   inc_pos;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

// File: design/lps_ifs.sv
// Stream interfaces for the line pixel stepper channels.
// Depends on lps_pkg for the coordinate width.
interface lps_in_if;
	logic                valid;
	logic                ready;
	logic                operation;
	lps_pkg::coord_t     x_start;
	lps_pkg::coord_t     y_start;
	lps_pkg::coord_t     x_end;
	lps_pkg::coord_t     y_end;

	modport source(output valid, output operation, output x_start, output y_start,
		output x_end, output y_end, input ready);
	modport sink(input valid, input operation, input x_start, input y_start,
		input x_end, input y_end, output ready);
endinterface

interface lps_out_if;
	logic                valid;
	logic                ready;
	lps_pkg::coord_t     pixel_x;
	lps_pkg::coord_t     pixel_y;
	logic                last_pixel;

	modport source(output valid, output pixel_x, output pixel_y, output last_pixel,
		input ready);
	modport sink(input valid, input pixel_x, input pixel_y, input last_pixel,
		output ready);
endinterface

// File: design/line_pixel_stepper.sv
// Line pixel stepper: Bresenham rasterizer for all octants, top level.
// Depends on lps_pkg, lps_ifs, lps_front, lps_cmd_fifo and lps_back.
//
// Usage:
//   in_ch carries commands. operation = load takes x_start/y_start and
//   x_end/y_end, sets up the line and returns the start pixel. operation = step
//   advances one pixel along the major axis and returns it; a step with no line
//   in progress returns nothing. A load during a line drops the old line.
//   out_ch carries pixel_x/pixel_y and last_pixel, set on the final pixel of a
//   line (also on the start pixel of a zero-length line).
// Path: a command transfer writes the command queue; the back end then pops
//   the command and loads the output register once that register is free or
//   is being taken.
// Throughput: one command and one pixel per cycle while out_ch.ready is high;
//   each step is one or two coordinate increments and one decision add in the back end.
// Reset: arst_n clears the queue, the output valid and the line-active flag;
//   no line is in progress afterwards.
// Stall: while out_ch.ready is low the back end holds its result; the
//   two-entry queue keeps taking commands until full, then in_ch.ready drops.
module line_pixel_stepper (
	input  logic      clk,
	input  logic      arst_n,
	lps_in_if.sink    in_ch,
	lps_out_if.source out_ch
);

	lps_pkg::cmd_t front_cmd;
	lps_pkg::cmd_t queue_cmd;
	lps_pkg::hs_t  push_hs;
	lps_pkg::hs_t  pop_hs;
	logic          queue_full;

	// front: classify and precompute deltas, directions and decision steps
	lps_front u_front (
		.operation (in_ch.operation),
		.x_start   (in_ch.x_start),
		.y_start   (in_ch.y_start),
		.x_end     (in_ch.x_end),
		.y_end     (in_ch.y_end),
		.cmd       (front_cmd)
	);

	// accept whenever the queue has room
	assign push_hs.ready = !queue_full;
	assign push_hs.valid = in_ch.valid;
	assign in_ch.ready   = push_hs.ready;

	lps_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_hs.valid && push_hs.ready),
		.push_data (front_cmd),
		.full      (queue_full),
		.pop       (pop_hs.ready),
		.not_empty (pop_hs.valid),
		.pop_data  (queue_cmd)
	);

	// back: run the line state and drive the output register
	lps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (pop_hs.valid),
		.cmd        (queue_cmd),
		.cmd_pop    (pop_hs.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.pixel_x    (out_ch.pixel_x),
		.pixel_y    (out_ch.pixel_y),
		.last_pixel (out_ch.last_pixel)
	);

endmodule

// File: design/lps_front.sv
// Front end: classify an input item and precompute the line setup.
// Depends on lps_pkg.
module lps_front (
	input  logic              operation,
	input  lps_pkg::coord_t   x_start,
	input  lps_pkg::coord_t   y_start,
	input  lps_pkg::coord_t   x_end,
	input  lps_pkg::coord_t   y_end,
	output lps_pkg::cmd_t     cmd
);

	lps_pkg::coord_t dx;
	lps_pkg::coord_t dy;
	lps_pkg::coord_t minor;
	logic            x_fwd;
	logic            y_fwd;
	logic            steep;
	lps_pkg::dec_t   minor2;
	lps_pkg::dec_t   major2;

	always_comb begin
		x_fwd  = x_end > x_start;
		y_fwd  = y_end > y_start;
		dx     = x_fwd ? (x_end - x_start) : (x_start - x_end);
		dy     = y_fwd ? (y_end - y_start) : (y_start - y_end);
		// ties go to y as the major axis
		steep  = !(dx > dy);
		minor  = steep ? dx : dy;
		minor2 = {2'b00, minor, 1'b0};

		cmd.is_load  = (lps_pkg::op_t'(operation) == lps_pkg::OP_LOAD);
		cmd.xs       = x_start;
		cmd.ys       = y_start;
		cmd.major    = steep ? dy : dx;
		cmd.x_back   = !x_fwd;
		cmd.y_back   = !y_fwd;
		cmd.steep    = steep;
		major2       = {2'b00, cmd.major, 1'b0};
		cmd.dec_init = minor2 - {3'b000, cmd.major};
		cmd.inc_neg  = minor2;
		cmd.inc_pos  = minor2 - major2;
	end

endmodule

// File: design/lps_cmd_fifo.sv
// Two-entry command queue between front and back end.
// Depends on lps_pkg.
module lps_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lps_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output lps_pkg::cmd_t pop_data
);

	lps_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/lps_back.sv
// Back end: hold the line state, step one pixel per command, register the result.
// Depends on lps_pkg.
module lps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_avail,
	input  lps_pkg::cmd_t   cmd,
	output logic            cmd_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output lps_pkg::coord_t pixel_x,
	output lps_pkg::coord_t pixel_y,
	output logic            last_pixel
);

	lps_pkg::coord_t cur_x_q;
	lps_pkg::coord_t cur_y_q;
	lps_pkg::dec_t   decision_q;
	lps_pkg::dec_t   inc_neg_q;
	lps_pkg::dec_t   inc_pos_q;
	lps_pkg::coord_t steps_left_q;
	logic            x_back_q;
	logic            y_back_q;
	logic            steep_q;
	logic            active_q;
	logic            out_valid_q;
	lps_pkg::coord_t pixel_x_q;
	lps_pkg::coord_t pixel_y_q;
	logic            last_q;

	lps_pkg::coord_t next_x;
	lps_pkg::coord_t next_y;
	lps_pkg::dec_t   next_dec;
	lps_pkg::coord_t next_steps;
	logic            dec_neg;
	logic            do_step;

	assign cmd_pop    = cmd_avail && (!out_valid_q || out_ready);
	assign do_step    = cmd_pop && !cmd.is_load && active_q;
	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_q;

	always_comb begin
		dec_neg    = decision_q[lps_pkg::DEC_BITS-1];
		next_x     = cur_x_q;
		next_y     = cur_y_q;
		// major axis always moves, minor only when the decision is not negative
		if (!dec_neg || !steep_q) begin
			next_x = x_back_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		end
		if (!dec_neg || steep_q) begin
			next_y = y_back_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
		end
		next_dec   = decision_q + (dec_neg ? inc_neg_q : inc_pos_q);
		next_steps = steps_left_q - 1'b1;
	end

	// line state and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.is_load) begin
			cur_x_q      <= cmd.xs;
			cur_y_q      <= cmd.ys;
			decision_q   <= cmd.dec_init;
			inc_neg_q    <= cmd.inc_neg;
			inc_pos_q    <= cmd.inc_pos;
			steps_left_q <= cmd.major;
			x_back_q     <= cmd.x_back;
			y_back_q     <= cmd.y_back;
			steep_q      <= cmd.steep;
			pixel_x_q    <= cmd.xs;
			pixel_y_q    <= cmd.ys;
			last_q       <= (cmd.major == '0);
		end else if (do_step) begin
			cur_x_q      <= next_x;
			cur_y_q      <= next_y;
			decision_q   <= next_dec;
			steps_left_q <= next_steps;
			pixel_x_q    <= next_x;
			pixel_y_q    <= next_y;
			last_q       <= (next_steps == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop && cmd.is_load) begin
				active_q    <= (cmd.major != '0);
				out_valid_q <= 1'b1;
			end else if (do_step) begin
				active_q    <= (next_steps != '0);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
